// ===== src/scba_pkg.sv =====
package scba_pkg;

	localparam int CFG_CLASSES = 4;
	localparam int SIZE_W = 16;
	localparam int SPR_W = 6;
	localparam int STAT_W = 3;
	localparam int HANDLE_W = 32;
	localparam int CLS_IDX_W = 2;
	localparam int RUN_IDX_W = 4;
	localparam int SLOT_IDX_W = 5;
	localparam int RUNS_OPEN_W = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CLASS_SIZE_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_RUN_0 = 3'd4;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK = 3'd0,
		STAT_ZERO_SIZE = 3'd1,
		STAT_NOT_SMALL = 3'd2,
		STAT_OUT_OF_RUNS = 3'd3,
		STAT_BAD_HANDLE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASS,
		S_READ,
		S_CHECK,
		S_OPEN
	} state_t;

	typedef struct packed {
		status_t status;
		logic [HANDLE_W-1:0] handle;
		logic [CLS_IDX_W-1:0] cls;
		logic [RUN_IDX_W-1:0] run;
		logic [SLOT_IDX_W-1:0] slot;
	} res_t;

endpackage

// ===== src/size_class_bitmap_slot_allocator_unit.sv =====
// A request is taken only in idle. The class search steps up from class 0 until the size fits;
// a rejected request gives its result from the search. A free then reads and checks its run's
// slot bitmap. An allocate checks each open run's bitmap from the newest down and opens a new
// run when none has a free slot, or reports that no run is left. A low out_ready adds its stall;
// the unit goes back to idle as the result is registered. Reset (arst_n low, asynchronous)
// restores the default class sizes and slot counts, closes runs, frees slots.
module size_class_bitmap_slot_allocator_unit import scba_pkg::*; #(
	parameter int NUM_CLASSES = 4,
	parameter int MAX_RUNS = 16,
	parameter int SLOT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [HANDLE_W-1:0] handle_in,
	output logic out_valid,
	input  logic out_ready,
	output logic [STAT_W-1:0] status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [CLS_IDX_W-1:0] class_index,
	output logic [RUN_IDX_W-1:0] run_index,
	output logic [SLOT_IDX_W-1:0] slot_index
);

	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int RUN_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int SLOT_W = (SLOT_BITS > 1) ? $clog2(SLOT_BITS) : 1;
	localparam int ADDR_W = CLS_W + RUN_W;
	localparam int DEPTH = 2 ** ADDR_W;
	localparam logic [CLS_IDX_W-1:0] CLS_LAST = CLS_IDX_W'(NUM_CLASSES - 1);
	localparam logic [RUNS_OPEN_W-1:0] RUNS_MAX = RUNS_OPEN_W'(MAX_RUNS);
	localparam logic [SPR_W-1:0] SLOTS_MAX = SPR_W'(SLOT_BITS);

	state_t state_q, state_nxt;

	logic [SIZE_W-1:0] class_size_q [CFG_CLASSES];
	logic [SPR_W-1:0] slots_q [CFG_CLASSES];
	logic [RUNS_OPEN_W-1:0] runs_open_q [NUM_CLASSES];

	logic [SLOT_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [SLOT_BITS-1:0] rdata_q;
	logic vld_rd_q;

	logic mode_q;
	logic flag_q;
	logic [SIZE_W-1:0] key_q;
	logic [CLS_IDX_W-1:0] cls_q;
	logic [RUN_IDX_W-1:0] run_q;
	logic [SLOT_IDX_W-1:0] slot_q;
	logic [RUNS_OPEN_W-1:0] nr_q;

	res_t out_q;
	logic out_valid_q;

	logic out_free;
	logic in_acc;
	logic early_err;
	logic key_le;
	logic is_last;
	logic [RUNS_OPEN_W-1:0] ro;
	logic [RUNS_OPEN_W-1:0] nr_clamp;
	logic [SPR_W-1:0] spr_raw;
	logic [SPR_W-1:0] cnt;
	logic [SLOT_BITS-1:0] mask;
	logic [SLOT_BITS-1:0] word;
	logic [SLOT_BITS-1:0] freeb;
	logic [SLOT_W-1:0] low_s;
	logic [SLOT_BITS-1:0] slot_hot;
	logic [SLOT_BITS-1:0] low_hot;
	logic free_bad;
	logic [SIZE_W-1:0] csize;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] open_addr;

	logic fin_req;
	logic done;
	res_t res;
	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [SLOT_BITS-1:0] mem_wdata;
	logic ro_we;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;

	always_comb begin
		ro = runs_open_q[cls_q[CLS_W-1:0]];
		nr_clamp = (ro > RUNS_MAX) ? RUNS_MAX : ro;
		csize = class_size_q[cls_q];
		spr_raw = slots_q[cls_q];
		if (spr_raw == '0) begin
			cnt = SPR_W'(1);
		end else if (spr_raw > SLOTS_MAX) begin
			cnt = SLOTS_MAX;
		end else begin
			cnt = spr_raw;
		end
		for (int i = 0; i < SLOT_BITS; i++) begin
			mask[i] = (SPR_W'(i) < cnt);
		end
		early_err = (mode_q == MODE_ALLOC) ? (key_q == '0) : !flag_q;
		key_le = (key_q <= csize);
		is_last = (cls_q == CLS_LAST);
		free_bad = ({1'b0, run_q} >= ro) || ({1'b0, run_q} >= RUNS_MAX) ||
			({1'b0, slot_q} >= cnt);
		word = vld_rd_q ? rdata_q : '0;
		freeb = ~word & mask;
		low_s = '0;
		for (int i = SLOT_BITS - 1; i >= 0; i--) begin
			if (freeb[i]) begin
				low_s = SLOT_W'(i);
			end
		end
		low_hot = SLOT_BITS'(1) << low_s;
		slot_hot = SLOT_BITS'(1) << slot_q[SLOT_W-1:0];
		cur_addr = {cls_q[CLS_W-1:0], run_q[RUN_W-1:0]};
		open_addr = {cls_q[CLS_W-1:0], nr_q[RUN_W-1:0]};
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_nxt = S_CLASS;
				end
			end
			S_CLASS: begin
				priority if (early_err || (!key_le && is_last) ||
						(key_le && mode_q == MODE_FREE && free_bad)) begin
					if (out_free) begin
						state_nxt = S_IDLE;
					end
				end else if (!key_le) begin
					state_nxt = S_CLASS;
				end else if (mode_q == MODE_ALLOC && nr_clamp == '0) begin
					state_nxt = S_OPEN;
				end else begin
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				priority if (mode_q == MODE_FREE || freeb != '0) begin
					if (out_free) begin
						state_nxt = S_IDLE;
					end
				end else if (run_q == '0) begin
					state_nxt = S_OPEN;
				end else begin
					state_nxt = S_READ;
				end
			end
			S_OPEN: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		fin_req = 1'b0;
		res = '{status: STAT_OK, handle: '0, cls: '0, run: '0, slot: '0};
		mem_we = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = word;
		ro_we = 1'b0;
		unique case (state_q)
			S_CLASS: begin
				priority if (early_err) begin
					fin_req = 1'b1;
					res.status = (mode_q == MODE_ALLOC) ? STAT_ZERO_SIZE : STAT_BAD_HANDLE;
				end else if (!key_le && is_last) begin
					fin_req = 1'b1;
					res.status = (mode_q == MODE_ALLOC) ? STAT_NOT_SMALL : STAT_BAD_HANDLE;
				end else if (key_le && mode_q == MODE_FREE && free_bad) begin
					fin_req = 1'b1;
					res.status = STAT_BAD_HANDLE;
				end else begin
					fin_req = 1'b0;
				end
			end
			S_CHECK: begin
				priority if (mode_q == MODE_FREE) begin
					fin_req = 1'b1;
					if ((word & slot_hot) == '0) begin
						res.status = STAT_BAD_HANDLE;
					end else begin
						res.cls = cls_q;
						res.run = run_q;
						res.slot = slot_q;
						mem_wdata = word & ~slot_hot;
						mem_we = 1'b1;
					end
				end else if (freeb != '0) begin
					fin_req = 1'b1;
					res.cls = cls_q;
					res.run = run_q;
					res.slot = SLOT_IDX_W'(low_s);
					res.handle = {1'b1, 3'b000, run_q, 3'b000, SLOT_IDX_W'(low_s), csize};
					mem_wdata = word | low_hot;
					mem_we = 1'b1;
				end else begin
					fin_req = 1'b0;
				end
			end
			S_OPEN: begin
				fin_req = 1'b1;
				res.cls = cls_q;
				if (nr_q >= RUNS_MAX) begin
					res.status = STAT_OUT_OF_RUNS;
				end else begin
					res.run = nr_q[RUN_IDX_W-1:0];
					res.handle = {1'b1, 3'b000, nr_q[RUN_IDX_W-1:0], 3'b000,
						SLOT_IDX_W'(0), csize};
					mem_waddr = open_addr;
					mem_wdata = SLOT_BITS'(1);
					mem_we = 1'b1;
					ro_we = 1'b1;
				end
			end
			S_IDLE, S_READ: begin
				fin_req = 1'b0;
			end
			default: fin_req = 1'b0;
		endcase
		done = fin_req && out_free;
		mem_we = mem_we && done;
		ro_we = ro_we && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			vld_q <= '0;
			vld_rd_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				runs_open_q[i] <= '0;
			end
			class_size_q[0] <= SIZE_W'(32);
			class_size_q[1] <= SIZE_W'(64);
			class_size_q[2] <= SIZE_W'(128);
			class_size_q[3] <= SIZE_W'(256);
			for (int i = 0; i < CFG_CLASSES; i++) begin
				slots_q[i] <= SPR_W'(32);
			end
		end else begin
			state_q <= state_nxt;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			if (state_q == S_READ) begin
				vld_rd_q <= vld_q[cur_addr];
			end
			if (ro_we) begin
				runs_open_q[cls_q[CLS_W-1:0]] <= nr_q + RUNS_OPEN_W'(1);
			end
			if (cfg_write) begin
				if (cfg_index < REG_SLOTS_PER_RUN_0) begin
					class_size_q[cfg_index[1:0] - REG_CLASS_SIZE_0[1:0]] <= cfg_data;
				end else begin
					slots_q[cfg_index[1:0] - REG_SLOTS_PER_RUN_0[1:0]] <= cfg_data[SPR_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_READ) begin
			rdata_q <= mem[cur_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
		if (in_acc) begin
			mode_q <= mode;
			key_q <= (mode == MODE_FREE) ? handle_in[SIZE_W-1:0] : request_size;
			flag_q <= handle_in[31];
			run_q <= handle_in[27:24];
			slot_q <= handle_in[20:16];
			cls_q <= '0;
		end else if (state_q == S_CLASS && !early_err) begin
			if (!key_le && !is_last) begin
				cls_q <= cls_q + CLS_IDX_W'(1);
			end else if (key_le && mode_q == MODE_ALLOC) begin
				nr_q <= nr_clamp;
				run_q <= nr_clamp[RUN_IDX_W-1:0] - RUN_IDX_W'(1);
			end
		end else if (state_q == S_CHECK && mode_q == MODE_ALLOC && freeb == '0 &&
				run_q != '0) begin
			run_q <= run_q - RUN_IDX_W'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign handle_out = out_q.handle;
	assign class_index = out_q.cls;
	assign run_index = out_q.run;
	assign slot_index = out_q.slot;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> handle_out == '0)
		else $error("error result carries a handle");

	assert property (@(posedge clk) disable iff (!arst_n)
		ro_we |-> nr_q < RUNS_MAX && mode_q == MODE_ALLOC)
		else $error("run opened beyond the run limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> done && (state_q == S_CHECK || state_q == S_OPEN))
		else $error("slot bitmap written outside a finishing step");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid && in_ready)
		else $error("finished request not presented");
`endif

endmodule
